/* rtl/grt_pkg.sv */
// Package for the gamepad report translator: field widths, constants and the
// structures passed between the top level and the translation pipeline.
// Depends on nothing.
package grt_pkg;

   localparam int ByteW = 8;
   localparam int RawBytes = 10;
   localparam int PayloadBytes = 9;
   localparam int LenW = 7;
   localparam int DeadzoneW = 7;
   localparam int ExtraW = 3;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW = 8;
   localparam int ReqDataW = 88;
   localparam int RspDataW = 80;

   localparam logic [ByteW-1:0] PrefixId = 8'h03;
   localparam logic [ByteW-1:0] Centre = 8'd128;
   localparam logic [ByteW-1:0] BatteryFull = 8'h1B;
   localparam logic [3:0] HatNone = 4'd8;
   localparam logic [ByteW-1:0] HatMax = 8'd7;
   localparam logic [LenW-1:0] MinLength = 7'd9;
   localparam logic [LenW-1:0] PrefixLength = 7'd10;

   localparam logic [CsrIndexW-1:0] RegOutputMode = 2'd0;
   localparam logic [CsrIndexW-1:0] RegDeadzone = 2'd1;
   localparam logic [CsrIndexW-1:0] RegTriggerThreshold = 2'd2;

   localparam logic [DeadzoneW-1:0] DeadzoneReset = 7'd6;
   localparam logic [ByteW-1:0] ThresholdReset = 8'd40;

   typedef struct packed {
      logic                 output_mode;
      logic [DeadzoneW-1:0] deadzone;
      logic [ByteW-1:0]     trigger_threshold;
   } grt_cfg_type;

   typedef struct packed {
      logic [RawBytes-1:0][ByteW-1:0] raw;
      logic [LenW-1:0]                report_length;
   } grt_req_type;

   typedef struct packed {
      logic              valid_res;
      logic [ByteW-1:0]  left_x;
      logic [ByteW-1:0]  left_y;
      logic [ByteW-1:0]  right_x;
      logic [ByteW-1:0]  right_y;
      logic [ByteW-1:0]  hat_and_face;
      logic [ByteW-1:0]  buttons_main;
      logic [ExtraW-1:0] buttons_extra;
      logic [ByteW-1:0]  trig_left;
      logic [ByteW-1:0]  trig_right;
      logic [ByteW-1:0]  battery_byte;
   } grt_rsp_type;

   function automatic logic [ByteW-1:0] stick_offset(input logic [ByteW-1:0] b);
      logic [ByteW-1:0] mag;
      if (b[ByteW-1]) begin
         mag = b - Centre;
      end else begin
         mag = Centre - b;
      end
      return mag;
   endfunction

endpackage

/* rtl/grt_core.sv */
// Three-stage translation pipeline: payload selection, stick and trigger
// comparison, then result assembly into the output register.
// Depends on grt_pkg.
module grt_core (
   input  logic                 clock,
   input  logic                 reset,
   input  grt_pkg::grt_cfg_type cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  grt_pkg::grt_req_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output grt_pkg::grt_rsp_type out_item
);
   import grt_pkg::*;

   logic en_a, en_b, en_c;

   // Stage A: prefix stripped, length checked.
   logic                               a_valid_ff, a_valid_in;
   logic                               a_ok_ff, a_ok_in;
   logic [PayloadBytes-1:0][ByteW-1:0] a_r_ff, a_r_in;
   logic                               prefixed;

   // Stage B: stick offsets compared, buttons remapped.
   logic                b_valid_ff;
   logic                b_ok_ff, b_ok_in;
   logic [3:0][ByteW-1:0] b_stick_ff, b_stick_in;
   logic [3:0]          b_snap_ff, b_snap_in;
   logic [ByteW-1:0]    b_hf_ff, b_hf_in;
   logic [ByteW-1:0]    b_bm_ff, b_bm_in;
   logic [ExtraW-1:0]   b_bx_ff, b_bx_in;
   logic [ByteW-1:0]    b_lt_ff, b_rt_ff;
   logic [3:0]          hat;

   // Stage C: output register.
   logic        c_valid_ff;
   grt_rsp_type c_rsp_ff, c_rsp_in;

   assign en_c = !c_valid_ff || out_ready;
   assign en_b = !b_valid_ff || en_c;
   assign en_a = !a_valid_ff || en_b;
   assign in_ready = en_a;
   assign a_valid_in = in_valid;

   always_comb begin
      prefixed = (in_item.raw[0] == PrefixId)
               && (in_item.report_length >= PrefixLength)
               && (in_item.raw[1] <= {4'd0, HatNone});
      a_ok_in = in_item.report_length >= MinLength;
      for (int i = 0; i < PayloadBytes; i++) begin
         a_r_in[i] = prefixed ? in_item.raw[i+1] : in_item.raw[i];
      end
   end

   always_comb begin
      b_ok_in = a_ok_ff;
      for (int i = 0; i < 4; i++) begin
         b_stick_in[i] = a_r_ff[i+3];
         b_snap_in[i] = stick_offset(a_r_ff[i+3]) < {1'b0, cfg.deadzone};
      end
      hat = (a_r_ff[0] <= HatMax) ? a_r_ff[0][3:0] : HatNone;
      b_hf_in = {a_r_ff[2][3], a_r_ff[2][5], a_r_ff[2][6], a_r_ff[2][4], hat};
      b_bm_in = {a_r_ff[1][7], a_r_ff[2][0], a_r_ff[1][5], a_r_ff[1][6],
                 a_r_ff[8] > cfg.trigger_threshold,
                 a_r_ff[7] > cfg.trigger_threshold,
                 a_r_ff[2][1], a_r_ff[2][2]};
      b_bx_in = {a_r_ff[1][0], a_r_ff[1][1], a_r_ff[1][4]};
   end

   always_comb begin
      c_rsp_in = '0;
      if (b_ok_ff) begin
         c_rsp_in.valid_res = 1'b1;
         c_rsp_in.left_x = b_snap_ff[0] ? Centre : b_stick_ff[0];
         c_rsp_in.left_y = b_snap_ff[1] ? Centre : b_stick_ff[1];
         c_rsp_in.right_x = b_snap_ff[2] ? Centre : b_stick_ff[2];
         c_rsp_in.right_y = b_snap_ff[3] ? Centre : b_stick_ff[3];
         c_rsp_in.hat_and_face = b_hf_ff;
         c_rsp_in.buttons_main = b_bm_ff;
         c_rsp_in.buttons_extra = {b_bx_ff[2] & cfg.output_mode, b_bx_ff[1:0]};
         c_rsp_in.trig_left = b_lt_ff;
         c_rsp_in.trig_right = b_rt_ff;
         c_rsp_in.battery_byte = cfg.output_mode ? '0 : BatteryFull;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_valid_ff <= a_valid_in;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (en_c) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_ok_ff <= a_ok_in;
         a_r_ff <= a_r_in;
      end
      if (en_b) begin
         b_ok_ff <= b_ok_in;
         b_stick_ff <= b_stick_in;
         b_snap_ff <= b_snap_in;
         b_hf_ff <= b_hf_in;
         b_bm_ff <= b_bm_in;
         b_bx_ff <= b_bx_in;
         b_lt_ff <= a_r_ff[7];
         b_rt_ff <= a_r_ff[8];
      end
      if (en_c) begin
         c_rsp_ff <= c_rsp_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_item = c_rsp_ff;

`ifndef NO_ASSERTIONS
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !c_rsp_ff.valid_res) |-> (c_rsp_ff == '0))
      else $error("rejected report carries non-zero fields");

   a_hat_range: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && c_rsp_ff.valid_res) |-> (c_rsp_ff.hat_and_face[3:0] <= HatNone))
      else $error("hat value out of range");

   a_stage_b_hold: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !en_c) |=> b_valid_ff)
      else $error("stalled word lost in middle stage");

   a_mode_battery: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && c_rsp_ff.buttons_extra[2]) |-> (c_rsp_ff.battery_byte == '0))
      else $error("mute bit set with non-zero battery byte");
`endif

endmodule

/* rtl/gamepad_report_translator.sv */
// Top level of the gamepad report translator: stream ports, configuration
// registers and the translation pipeline.
// Depends on grt_pkg and grt_core.
//
//   channel | direction | contents
//   req     | in        | raw report bytes 0..9 and report length
//   rsp     | out       | translated host report
//   csr     | in        | write-only registers: mode, deadzone, threshold
//
// Each word passes through the pipeline registers in turn, the third being the output
// register; one word can be taken every cycle while rsp is not stalled.
// Reset clears the pipeline valid bits and restores the register defaults.
// A stall on rsp holds the output register; an earlier stage holds its word
// only while every stage after it is held, so empty stages still fill.
module gamepad_report_translator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // byte0..byte9 (8 bits each), report_length (7), zero pad (1)
   input  logic [grt_pkg::ReqDataW-1:0]    req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // valid_res, left_x, left_y, right_x, right_y, hat_and_face, buttons_main,
   // buttons_extra (3), trig_left, trig_right, battery_byte, zero pad (4)
   output logic [grt_pkg::RspDataW-1:0]    rsp_tdata,
   input  logic                            csr_we,
   input  logic [grt_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [grt_pkg::CsrDataW-1:0]    csr_wdata
);
   import grt_pkg::*;

   grt_cfg_type cfg_ff;
   grt_req_type req_item;
   grt_rsp_type rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_mode <= 1'b0;
         cfg_ff.deadzone <= DeadzoneReset;
         cfg_ff.trigger_threshold <= ThresholdReset;
      end else if (csr_we) begin
         case (csr_index)
            RegOutputMode: cfg_ff.output_mode <= csr_wdata[0];
            RegDeadzone: cfg_ff.deadzone <= csr_wdata[DeadzoneW-1:0];
            RegTriggerThreshold: cfg_ff.trigger_threshold <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < RawBytes; i++) begin
         req_item.raw[i] = req_tdata[i*ByteW +: ByteW];
      end
      req_item.report_length = req_tdata[RawBytes*ByteW +: LenW];
   end

   grt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = {4'd0,
                       rsp_item.battery_byte,
                       rsp_item.trig_right,
                       rsp_item.trig_left,
                       rsp_item.buttons_extra,
                       rsp_item.buttons_main,
                       rsp_item.hat_and_face,
                       rsp_item.right_y,
                       rsp_item.right_x,
                       rsp_item.left_y,
                       rsp_item.left_x,
                       rsp_item.valid_res};

endmodule
